/* rtl/core/mtf_pkg.sv */
// ----------------------------------------------------------------------------
// mtf_pkg - shared types for the move-to-front key list
// Operation and status codes, controller states and the command word that
// the controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 8;

  // operation codes of an input beat
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // status codes of a result beat
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE
  } state_t;

  // command broadcast to all cells
  typedef struct packed {
    logic advance;       // move scan token one cell back
    logic clear;         // drop token and passed marks
    logic shift_all;     // insert: every cell takes its neighbor's entry
    logic shift_passed;  // move to front: cells the token passed shift
  } cell_cmd_t;

endpackage

/* rtl/core/mtf_if.sv */
// ----------------------------------------------------------------------------
// mtf_in_if / mtf_out_if - request and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mtf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [mtf_pkg::KEY_W-1:0]         key;
  logic signed [mtf_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output op, output key, output data_in, input ready);
  modport sink   (input valid, input op, input key, input data_in, output ready);
endinterface

interface mtf_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [mtf_pkg::DATA_W-1:0] data_out;
  logic [mtf_pkg::COUNT_W-1:0]       entry_count;

  modport source (output valid, output status, output data_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input data_out, input entry_count,
                  output ready);
endinterface

/* rtl/core/mtf_cell.sv */
// ----------------------------------------------------------------------------
// mtf_cell - one slot of the key list
// Holds a key, a data word and a valid bit, takes its front neighbor's entry
// on a shift, and passes the scan token one cell back per cycle on an advance command.
// ----------------------------------------------------------------------------
module mtf_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mtf_pkg::cell_cmd_t                cmd,
  input  logic [mtf_pkg::KEY_W-1:0]         query_key,
  input  logic [mtf_pkg::KEY_W-1:0]         prev_key,
  input  logic signed [mtf_pkg::DATA_W-1:0] prev_data,
  input  logic                              prev_valid,
  input  logic                              prev_tok,
  output logic [mtf_pkg::KEY_W-1:0]         key_o,
  output logic signed [mtf_pkg::DATA_W-1:0] data_o,
  output logic                              valid_o,
  output logic                              tok_o,
  output logic                              hit,
  output logic signed [mtf_pkg::DATA_W-1:0] hit_data
);

  logic [mtf_pkg::KEY_W-1:0]         key_r;
  logic signed [mtf_pkg::DATA_W-1:0] data_r;
  logic                              valid_r, valid_nxt;
  logic                              tok_r, tok_nxt;
  logic                              passed_r, passed_nxt;
  logic                              shift;

  // token and passed marks
  always_comb begin
    tok_nxt    = tok_r;
    passed_nxt = passed_r;
    if (cmd.clear) begin
      tok_nxt    = 1'b0;
      passed_nxt = 1'b0;
    end else if (cmd.advance) begin
      tok_nxt    = prev_tok;
      passed_nxt = passed_r | prev_tok;
    end
  end

  assign shift     = cmd.shift_all | (cmd.shift_passed & passed_r);
  assign valid_nxt = shift ? prev_valid : valid_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      tok_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      tok_r    <= tok_nxt;
      passed_r <= passed_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r  <= prev_key;
      data_r <= prev_data;
    end
  end

  // compare only where the token sits
  assign hit      = tok_r & valid_r & (key_r == query_key);
  assign hit_data = hit ? data_r : '0;

  assign key_o   = key_r;
  assign data_o  = data_r;
  assign valid_o = valid_r;
  assign tok_o   = tok_r;

endmodule

/* rtl/core/move_to_front_key_list.sv */
// ----------------------------------------------------------------------------
// move_to_front_key_list - bounded self-organizing key/data list
// A chain of CAPACITY cells with a front-to-back scan token and a controller.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch (op, key, data_in) and one result beat per
// request leaves on out_ch (status, data_out, entry_count).
// On an insert every cell takes its front neighbor's entry and the new pair
// lands in the front cell; the result is registered on the same edge.
// An insert into a full list is answered with the full status, list unchanged.
// A search walks a token from the front cell back, one cell per cycle. On a
// hit the controller captures the matched data, then shifts the cells the
// token passed to move the pair to the front and loads the result beat; a
// miss is answered once the token reaches the last held entry, and a search
// of an empty list is answered with a miss on the edge that accepts it.
// One request is worked on at a time; in_ch.ready is high only when the
// controller is idle and the result register is free or being drained.
// While the receiver stalls, a finished search waits with the list untouched.
// Reset (rst_n low, synchronous) empties the list; stored keys and data are
// not cleared, only the valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module move_to_front_key_list #(
  parameter int CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  mtf_in_if.sink    in_ch,
  mtf_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // chain wiring, index 0 is the front neighbor of cell 0
  logic [mtf_pkg::KEY_W-1:0]         ch_key   [CAPACITY+1];
  logic signed [mtf_pkg::DATA_W-1:0] ch_data  [CAPACITY+1];
  logic                              ch_valid [CAPACITY+1];
  logic                              ch_tok   [CAPACITY+1];
  logic                              cell_hit [CAPACITY];
  logic signed [mtf_pkg::DATA_W-1:0] cell_hd  [CAPACITY];

  mtf_pkg::cell_cmd_t cmd;
  mtf_pkg::state_t    state_r, state_nxt;

  logic [CW-1:0]                     held_r, held_nxt;
  logic [IW-1:0]                     idx_r, idx_nxt;
  logic [mtf_pkg::KEY_W-1:0]         query_r;
  logic signed [mtf_pkg::DATA_W-1:0] hit_data_r;
  logic                              capture_hit;
  logic                              load_query;

  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r;
  logic signed [mtf_pkg::DATA_W-1:0] out_data_r;
  logic [mtf_pkg::COUNT_W-1:0]       out_count_r;
  logic                              out_load;
  mtf_pkg::status_t                  res_status;
  logic signed [mtf_pkg::DATA_W-1:0] res_data;
  logic [CW+mtf_pkg::COUNT_W-1:0]    res_count_wide;

  logic                              out_free;
  logic                              in_fire;
  logic                              any_hit;
  logic signed [mtf_pkg::DATA_W-1:0] bus_data;
  logic                              scan_last;

  // front of the chain: new pair on insert, matched pair on move to front
  assign ch_key[0]   = (state_r == mtf_pkg::S_MOVE) ? query_r : in_ch.key;
  assign ch_data[0]  = (state_r == mtf_pkg::S_MOVE) ? hit_data_r : in_ch.data_in;
  assign ch_valid[0] = 1'b1;
  assign ch_tok[0]   = (state_r == mtf_pkg::S_IDLE);

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    mtf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .query_key  (query_r),
      .prev_key   (ch_key[g]),
      .prev_data  (ch_data[g]),
      .prev_valid (ch_valid[g]),
      .prev_tok   (ch_tok[g]),
      .key_o      (ch_key[g+1]),
      .data_o     (ch_data[g+1]),
      .valid_o    (ch_valid[g+1]),
      .tok_o      (ch_tok[g+1]),
      .hit        (cell_hit[g]),
      .hit_data   (cell_hd[g])
    );
  end

  // at most one cell holds the token, so hits merge by or
  always_comb begin
    any_hit  = 1'b0;
    bus_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_hit  = any_hit | cell_hit[i];
      bus_data = bus_data | cell_hd[i];
    end
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == mtf_pkg::S_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign scan_last = (CW'(idx_r) == held_r - CW'(1));

  // controller: next state, cell commands, result
  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    capture_hit = 1'b0;
    load_query  = 1'b0;
    out_load    = 1'b0;
    res_status  = mtf_pkg::ST_MISS;
    res_data    = '0;
    unique case (state_r)
      mtf_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == mtf_pkg::OP_INSERT) begin
            out_load = 1'b1;
            if (held_r == CW'(CAPACITY)) begin
              res_status = mtf_pkg::ST_FULL;
            end else begin
              cmd.shift_all = 1'b1;
              held_nxt      = held_r + CW'(1);
              res_status    = mtf_pkg::ST_INSERTED;
            end
          end else begin
            load_query = 1'b1;
            if (held_r == '0) begin
              out_load   = 1'b1;
              res_status = mtf_pkg::ST_MISS;
            end else begin
              cmd.advance = 1'b1;
              idx_nxt     = '0;
              state_nxt   = mtf_pkg::S_SCAN;
            end
          end
        end
      end
      mtf_pkg::S_SCAN: begin
        if (any_hit) begin
          capture_hit = 1'b1;
          state_nxt   = mtf_pkg::S_MOVE;
        end else if (scan_last) begin
          if (out_free) begin
            cmd.clear  = 1'b1;
            out_load   = 1'b1;
            res_status = mtf_pkg::ST_MISS;
            state_nxt  = mtf_pkg::S_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          idx_nxt     = idx_r + IW'(1);
        end
      end
      mtf_pkg::S_MOVE: begin
        if (out_free) begin
          cmd.shift_passed = 1'b1;
          cmd.clear        = 1'b1;
          out_load         = 1'b1;
          res_status       = mtf_pkg::ST_HIT;
          res_data         = hit_data_r;
          state_nxt        = mtf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtf_pkg::S_IDLE;
      end
    endcase
  end

  assign res_count_wide = {{mtf_pkg::COUNT_W{1'b0}}, held_nxt};
  assign out_valid_nxt  = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtf_pkg::S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan index, query and matched data
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (load_query) begin
      query_r <= in_ch.key;
    end
    if (capture_hit) begin
      hit_data_r <= bus_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_count_r  <= res_count_wide[mtf_pkg::COUNT_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.entry_count = out_count_r;

endmodule
